// ===== rtl/esd_pkg.sv =====
// Shared types and constants of the event stream deframer.
package esd_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam int unsigned PRELUDE_BYTES = 12;
	localparam int unsigned OVERHEAD = 16;
	localparam int unsigned EXC_LEN = 9;
	localparam logic [3:0] MISMATCH = 4'd15;

	localparam logic [1:0] ST_GOOD = 2'd0;
	localparam logic [1:0] ST_PRELUDE_CRC = 2'd1;
	localparam logic [1:0] ST_LENGTH = 2'd2;
	localparam logic [1:0] ST_MSG_CRC = 2'd3;

	typedef enum logic [4:0] {
		PH_PRE = 5'b00001,
		PH_HDR = 5'b00010,
		PH_PAY = 5'b00100,
		PH_CRC = 5'b01000,
		PH_OVF = 5'b10000
	} phase_t;

	typedef enum logic [5:0] {
		HF_NLEN = 6'b000001,
		HF_NAME = 6'b000010,
		HF_TYPE = 6'b000100,
		HF_VHI  = 6'b001000,
		HF_VLO  = 6'b010000,
		HF_VAL  = 6'b100000
	} hfield_t;

	// One result item as it passes through the queue.
	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		logic [1:0]  frame_status;
		logic        exception_seen;
		logic [23:0] payload_length;
	} result_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] exc_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0: ch = 8'h65;
			4'd1: ch = 8'h78;
			4'd2: ch = 8'h63;
			4'd3: ch = 8'h65;
			4'd4: ch = 8'h70;
			4'd5: ch = 8'h74;
			4'd6: ch = 8'h69;
			4'd7: ch = 8'h6F;
			4'd8: ch = 8'h6E;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== rtl/event_stream_deframer_crc32_top.sv =====
// Top level of the event stream message deframer with CRC-32 checking.
// The block takes a byte stream on s_axis, one byte per item, and parses
// length-prefixed event messages: a 12-byte prelude, headers, payload and a
// trailing CRC-32. Each payload byte leaves on m_axis as a payload item, and
// every message ends with one verdict item that carries the frame status,
// whether a header value read "exception", and the payload byte count.
// A prelude with a bad CRC or a bad length yields a verdict at its twelfth
// byte, and the next byte starts a new prelude.
// While s_axis_tready is high the parser takes one item per cycle; each result
// is registered in the parser and then in the queue before it reaches m_axis.
// The parser registers its result and hands it to a two-entry queue, so the
// input keeps flowing while the receiver takes the previous result.
// When the receiver stalls and the queue fills, s_axis_tready drops; nothing
// is lost. The cfg channel writes max_frame_length and is always ready;
// write it only while the block is idle.
// Reset clears all message state and sets max_frame_length to its maximum.
module event_stream_deframer_crc32_top #(
	parameter int LENGTH_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// payload_byte[7:0], frame_status[9:8], exception_seen[10], payload_length[34:11]
	output logic [39:0] m_axis_tdata,
	output logic        m_axis_tuser,   // result_kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data        // max_frame_length
);
	import esd_pkg::*;

	logic [23:0] max_len_q;
	logic        res_valid;
	logic        q_ready;
	result_t     res;
	result_t     out_item;
	logic        p_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 24'hFFFFFF;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	// The parser may advance only when its output register is free or drains.
	assign p_ready = !res_valid || q_ready;

	esd_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_byte(s_axis_tdata),
		.max_len(max_len_q),
		.res_ready(p_ready),
		.in_ready(s_axis_tready),
		.res_valid(res_valid),
		.res(res)
	);

	esd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(res_valid),
		.wr_data(res),
		.wr_ready(q_ready),
		.rd_valid(m_axis_tvalid),
		.rd_data(out_item),
		.rd_ready(m_axis_tready)
	);

	assign m_axis_tuser = out_item.kind;
	assign m_axis_tdata = {5'd0, out_item.payload_length, out_item.exception_seen,
		out_item.frame_status, out_item.payload_byte};
endmodule

// ===== rtl/esd_parser.sv =====
// Front part: walks the message byte by byte and produces result items.
module esd_parser #(
	parameter int LENGTH_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       in_byte,
	input  logic [23:0]      max_len,
	input  logic             res_ready,
	output logic             in_ready,
	output logic             res_valid,
	output esd_pkg::result_t res
);
	import esd_pkg::*;

	localparam int LB = LENGTH_BITS;

	phase_t          phase_q;
	logic [LB-1:0]   pos_q;
	logic [LB-1:0]   total_q;
	logic [LB-1:0]   hlen_q;
	logic [31:0]     crc_q;
	logic [31:0]     rcrc_q;
	hfield_t         hf_q;
	logic [15:0]     hcnt_q;
	logic [3:0]      match_q;
	logic            exc_q;
	logic [23:0]     pcount_q;

	logic            step;
	logic [LB-1:0]   pos_n;
	logic [31:0]     crc_n;
	logic [LB-1:0]   tot_m4;
	logic [LB-1:0]   hdr_end;
	logic [15:0]     hcnt_dec;
	logic [15:0]     vlen;

	assign in_ready = res_ready;
	assign step = in_valid && in_ready;
	assign pos_n = pos_q + LB'(1);
	assign crc_n = crc_byte(crc_q, in_byte);
	assign tot_m4 = total_q - LB'(4);
	assign hdr_end = LB'(PRELUDE_BYTES) + hlen_q;
	assign hcnt_dec = hcnt_q - 16'd1;
	assign vlen = {hcnt_q[15:8], in_byte};

	// Phase after the byte at pos_q, given the next position.
	function automatic phase_t next_phase(input logic [LB-1:0] np, input logic [LB-1:0] he,
		input logic [LB-1:0] t4);
		if (np < he) return PH_HDR;
		if (np < t4) return PH_PAY;
		return PH_CRC;
	endfunction

	logic          pre_ovf;
	logic [LB-1:0] t_next;
	logic [LB-1:0] h_next;
	logic [31:0]   rc_pre;
	logic          len_bad;
	logic [LB:0]   tot_ext;
	logic [LB+1:0] hdr_lim;

	always_comb begin
		pre_ovf = 1'b0;
		t_next = total_q;
		h_next = hlen_q;
		if (pos_q < LB'(4)) begin
			pre_ovf = total_q[LB-1 -: 8] != 8'd0;
			t_next = {total_q[LB-9:0], in_byte};
		end else if (pos_q < LB'(8)) begin
			pre_ovf = hlen_q[LB-1 -: 8] != 8'd0;
			h_next = {hlen_q[LB-9:0], in_byte};
		end
		rc_pre = rcrc_q ^ ({24'd0, in_byte} << (5'd8 * 5'(4'd11 - pos_q[3:0])));
		tot_ext = {1'b0, total_q};
		hdr_lim = {2'b0, hlen_q} + (LB+2)'(OVERHEAD);
		len_bad = (phase_q == PH_OVF) || (total_q < LB'(OVERHEAD))
			|| ({{LB{1'b0}}, max_len} < {24'd0, total_q})
			|| (hdr_lim > {1'b0, tot_ext});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRE;
			pos_q <= '0;
			total_q <= '0;
			hlen_q <= '0;
			crc_q <= '1;
			rcrc_q <= '0;
			hf_q <= HF_NLEN;
			hcnt_q <= '0;
			match_q <= '0;
			exc_q <= 1'b0;
			pcount_q <= '0;
			res_valid <= 1'b0;
			res <= '0;
		end else begin
			if (res_ready) res_valid <= 1'b0;
			if (step) begin
				pos_q <= pos_n;
				case (phase_q)
					PH_PRE, PH_OVF: begin
						total_q <= t_next;
						hlen_q <= h_next;
						if (pre_ovf) phase_q <= PH_OVF;
						crc_q <= crc_n;
						if (pos_q < LB'(8)) begin
							if (pos_q == LB'(7)) rcrc_q <= ~crc_n;
						end else begin
							rcrc_q <= rc_pre;
						end
						if (pos_q == LB'(11)) begin
							if (rc_pre != 32'd0 || len_bad) begin
								res_valid <= 1'b1;
								res <= '{1'b1, 8'd0,
									(rc_pre != 32'd0) ? ST_PRELUDE_CRC : ST_LENGTH,
									1'b0, 24'd0};
								phase_q <= PH_PRE;
								pos_q <= '0;
								total_q <= '0;
								hlen_q <= '0;
								crc_q <= '1;
								rcrc_q <= '0;
								hf_q <= HF_NLEN;
								hcnt_q <= '0;
								match_q <= '0;
								exc_q <= 1'b0;
								pcount_q <= '0;
							end else begin
								rcrc_q <= '0;
								hf_q <= HF_NLEN;
								hcnt_q <= '0;
								match_q <= '0;
								phase_q <= next_phase(pos_n, hdr_end, tot_m4);
							end
						end
					end
					PH_CRC: begin
						if (pos_n < total_q) begin
							rcrc_q <= ((pos_q == tot_m4) ? ~crc_q : rcrc_q)
								^ ({24'd0, in_byte} << (5'd8 * 5'(2'(total_q - LB'(1) - pos_q))));
						end else begin
							res_valid <= 1'b1;
							res <= '{1'b1, 8'd0,
								((((pos_q == tot_m4) ? ~crc_q : rcrc_q)
								^ ({24'd0, in_byte} << (5'd8 * 5'(2'(total_q - LB'(1) - pos_q)))))
								!= 32'd0) ? ST_MSG_CRC : ST_GOOD,
								exc_q, pcount_q};
							phase_q <= PH_PRE;
							pos_q <= '0;
							total_q <= '0;
							hlen_q <= '0;
							crc_q <= '1;
							rcrc_q <= '0;
							hf_q <= HF_NLEN;
							hcnt_q <= '0;
							match_q <= '0;
							exc_q <= 1'b0;
							pcount_q <= '0;
						end
					end
					PH_HDR: begin
						crc_q <= crc_n;
						phase_q <= next_phase(pos_n, hdr_end, tot_m4);
						case (hf_q)
							HF_NLEN: begin
								hcnt_q <= {8'd0, in_byte};
								hf_q <= (in_byte != 8'd0) ? HF_NAME : HF_TYPE;
							end
							HF_NAME: begin
								hcnt_q <= hcnt_dec;
								if (hcnt_dec == 16'd0) hf_q <= HF_TYPE;
							end
							HF_TYPE: hf_q <= HF_VHI;
							HF_VHI: begin
								hcnt_q <= {in_byte, 8'd0};
								hf_q <= HF_VLO;
							end
							HF_VLO: begin
								hcnt_q <= vlen;
								match_q <= (vlen == 16'(EXC_LEN)) ? 4'd0 : MISMATCH;
								hf_q <= (vlen != 16'd0) ? HF_VAL : HF_NLEN;
							end
							default: begin
								if (match_q < 4'(EXC_LEN) && in_byte == exc_char(match_q)) begin
									match_q <= match_q + 4'd1;
									if (hcnt_dec == 16'd0 && match_q == 4'(EXC_LEN - 1))
										exc_q <= 1'b1;
								end else begin
									match_q <= MISMATCH;
								end
								hcnt_q <= hcnt_dec;
								if (hcnt_dec == 16'd0) hf_q <= HF_NLEN;
							end
						endcase
					end
					default: begin
						crc_q <= crc_n;
						pcount_q <= pcount_q + 24'd1;
						phase_q <= next_phase(pos_n, hdr_end, tot_m4);
						res_valid <= 1'b1;
						res <= '{1'b0, in_byte, ST_GOOD, 1'b0, 24'd0};
					end
				endcase
			end
		end
	end
endmodule

// ===== rtl/esd_queue.sv =====
// Back part: a two-entry queue that decouples the parser from the output.
module esd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	input  esd_pkg::result_t wr_data,
	output logic             wr_ready,
	output logic             rd_valid,
	output esd_pkg::result_t rd_data,
	input  logic             rd_ready
);
	import esd_pkg::*;

	result_t     mem_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/esd_checker.sv =====
// Port-level checker of the deframer, bound to the top level.
module esd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_pay_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[39:8] == 32'd0)
		else $error("payload item carries verdict fields");
	a_verd_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0)
		else $error("verdict carries a payload byte");
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser && (m_axis_tdata[9:8] == 2'd1 || m_axis_tdata[9:8] == 2'd2)
		|-> m_axis_tdata[34:10] == 25'd0)
		else $error("prelude fault verdict carries message fields");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");
endmodule

bind event_stream_deframer_crc32_top esd_checker u_esd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser),
	.cfg_ready(cfg_ready)
);

// ===== test/tb_event_stream_deframer_crc32_top.sv =====
// Self-checking testbench of the event stream deframer with CRC-32 checking.
`timescale 1ns / 1ps

module tb_event_stream_deframer_crc32_top;
	import esd_pkg::*;

	// Phase codes of the predictor (kept local, one copy of the parse).
	typedef enum logic [2:0] {
		P_PRE, P_HDR, P_PAY, P_CRC, P_OVF
	} pphase_t;
	typedef enum logic [2:0] {
		F_NLEN, F_NAME, F_TYPE, F_VHI, F_VLO, F_VAL
	} pfield_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [23:0] cfg_data;

	event_stream_deframer_crc32_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	// Clock: 8 ns period.
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Bytes waiting to be offered, and the results they are predicted to cause.
	logic [7:0] byte_queue[$];
	result_t    result_queue[$];
	int         error_count;
	bit         send_idle_ok;   // driver may insert random gaps
	bit         recv_idle_ok;
	bit         in_taken;       // input item accepted at the last rising edge

	// Predictor state.
	logic [23:0] max_len;
	pphase_t     ph;
	logic [31:0] pos;
	logic [23:0] tot_len;
	logic [23:0] hdr_len;
	logic [31:0] run_crc;
	logic [31:0] rx_crc;
	pfield_t     hfs;
	logic [15:0] hcount;
	logic [3:0]  mpos;
	logic        exc_flag;
	logic [23:0] pay_cnt;

	function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
		return c;
	endfunction

	// CRC-32 with final inversion, for building messages.
	function automatic logic [31:0] crc_of(input logic [7:0] bytes[$]);
		logic [31:0] c;
		c = 32'hFFFFFFFF;
		foreach (bytes[i])
			c = crc_step(c, bytes[i]);
		return ~c;
	endfunction

	task automatic clear_parse();
		ph = P_PRE;
		pos = 0;
		tot_len = 0;
		hdr_len = 0;
		run_crc = 32'hFFFFFFFF;
		rx_crc = 0;
		hfs = F_NLEN;
		hcount = 0;
		mpos = 0;
		exc_flag = 0;
		pay_cnt = 0;
	endtask

	function automatic pphase_t phase_for(input logic [31:0] p);
		if (p < PRELUDE_BYTES + hdr_len)
			return P_HDR;
		if (p < tot_len - 4)
			return P_PAY;
		return P_CRC;
	endfunction

	task automatic push_verdict(input logic [1:0] st, input bit full);
		result_t r;
		r = '0;
		r.kind = 1'b1;
		r.frame_status = st;
		r.exception_seen = full ? exc_flag : 1'b0;
		r.payload_length = full ? pay_cnt : 24'd0;
		result_queue.push_back(r);
		clear_parse();
	endtask

	// Walks one header byte through name, type, value length and value.
	task automatic walk_header(input logic [7:0] b);
		case (hfs)
			F_NLEN: begin
				hcount = {8'd0, b};
				hfs = (b != 0) ? F_NAME : F_TYPE;
			end
			F_NAME: begin
				hcount = hcount - 1;
				if (hcount == 0)
					hfs = F_TYPE;
			end
			F_TYPE: hfs = F_VHI;
			F_VHI: begin
				hcount = {b, 8'd0};
				hfs = F_VLO;
			end
			F_VLO: begin
				hcount = hcount | {8'd0, b};
				mpos = (hcount == EXC_LEN) ? 4'd0 : MISMATCH;
				hfs = (hcount != 0) ? F_VAL : F_NLEN;
			end
			default: begin
				if (mpos < EXC_LEN && b == exc_char(mpos))
					mpos = mpos + 1;
				else
					mpos = MISMATCH;
				hcount = hcount - 1;
				if (hcount == 0) begin
					if (mpos == EXC_LEN)
						exc_flag = 1'b1;
					hfs = F_NLEN;
				end
			end
		endcase
	endtask

	// Predicts the results of one accepted byte.
	task automatic predict_byte(input logic [7:0] b);
		logic [31:0] p;
		bit ovf;
		result_t r;
		p = pos;
		if (ph == P_PRE || ph == P_OVF) begin
			ovf = 0;
			if (p < 4) begin
				ovf = (tot_len[23:16] != 0);
				tot_len = {tot_len[15:0], b};
			end else if (p < 8) begin
				ovf = (hdr_len[23:16] != 0);
				hdr_len = {hdr_len[15:0], b};
			end
			if (ovf)
				ph = P_OVF;
			run_crc = crc_step(run_crc, b);
			if (p < 8) begin
				if (p == 7)
					rx_crc = ~run_crc;
			end else begin
				rx_crc ^= {24'd0, b} << (8 * (11 - p));
			end
			pos = p + 1;
			if (p < 11)
				return;
			if (rx_crc != 0) begin
				push_verdict(ST_PRELUDE_CRC, 0);
				return;
			end
			if (ph == P_OVF || tot_len < OVERHEAD || tot_len > max_len ||
					hdr_len > tot_len - OVERHEAD) begin
				push_verdict(ST_LENGTH, 0);
				return;
			end
			rx_crc = 0;
			hfs = F_NLEN;
			hcount = 0;
			mpos = 0;
			ph = phase_for(pos);
			return;
		end
		if (ph == P_CRC) begin
			if (p == tot_len - 4)
				rx_crc = ~run_crc;
			rx_crc ^= {24'd0, b} << (8 * ((tot_len - 1 - p) & 3));
			pos = p + 1;
			if (pos < tot_len)
				return;
			push_verdict((rx_crc != 0) ? ST_MSG_CRC : ST_GOOD, 1);
			return;
		end
		run_crc = crc_step(run_crc, b);
		pos = p + 1;
		if (ph == P_HDR) begin
			walk_header(b);
			ph = phase_for(pos);
			return;
		end
		pay_cnt = pay_cnt + 1;
		ph = phase_for(pos);
		r = '0;
		r.payload_byte = b;
		result_queue.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [23:0] got,
			input logic [23:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		error_count++;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Driver: offers queued bytes at the falling edge; the byte leaves the queue
	// when the handshake completed at the previous rising edge.
	int send_gap;
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_taken) begin
				void'(byte_queue.pop_front());
				if (send_idle_ok)
					send_gap = gap_len();
			end
			if (!s_axis_tvalid || in_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (byte_queue.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= byte_queue[0];
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Input side sampled at the rising edge feeds the predictor.
	always @(posedge clk) begin
		in_taken = arst_n && s_axis_tvalid && s_axis_tready;
		if (in_taken)
			predict_byte(s_axis_tdata);
	end

	// Monitor: checks each accepted result against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (result_queue.size() == 0) begin
				report_mismatch("unexpected result kind", {23'd0, m_axis_tuser}, 24'd0);
			end else begin
				want = result_queue.pop_front();
				if (m_axis_tuser !== want.kind)
					report_mismatch("result_kind", {23'd0, m_axis_tuser}, {23'd0, want.kind});
				if (m_axis_tdata[7:0] !== want.payload_byte)
					report_mismatch("payload_byte", {16'd0, m_axis_tdata[7:0]},
						{16'd0, want.payload_byte});
				if (m_axis_tdata[9:8] !== want.frame_status)
					report_mismatch("frame_status", {22'd0, m_axis_tdata[9:8]},
						{22'd0, want.frame_status});
				if (m_axis_tdata[10] !== want.exception_seen)
					report_mismatch("exception_seen", {23'd0, m_axis_tdata[10]},
						{23'd0, want.exception_seen});
				if (m_axis_tdata[34:11] !== want.payload_length)
					report_mismatch("payload_length", m_axis_tdata[34:11], want.payload_length);
			end
		end
	end

	// Receiver backpressure.
	int recv_gap;
	always @(negedge clk) begin
		if (!arst_n || !recv_idle_ok) begin
			m_axis_tready <= 1'b1;
			recv_gap = 0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			recv_gap = gap_len();
			m_axis_tready <= (recv_gap == 0);
		end
	end

	// Builds one message with the given headers and payload, optionally
	// corrupting the prelude CRC or the message CRC.
	task automatic queue_message(input logic [7:0] hdrs[$], input logic [7:0] pay[$],
			input bit bad_pre, input bit bad_msg);
		logic [7:0] m[$];
		logic [31:0] tl;
		logic [31:0] hl;
		logic [31:0] c;
		tl = 16 + hdrs.size() + pay.size();
		hl = hdrs.size();
		m = {tl[31:24], tl[23:16], tl[15:8], tl[7:0], hl[31:24], hl[23:16], hl[15:8], hl[7:0]};
		c = crc_of(m);
		if (bad_pre)
			c[$urandom_range(0, 31)] ^= 1'b1;
		m = {m, c[31:24], c[23:16], c[15:8], c[7:0]};
		m = {m, hdrs, pay};
		c = crc_of(m);
		if (bad_msg)
			c[$urandom_range(0, 31)] ^= 1'b1;
		m = {m, c[31:24], c[23:16], c[15:8], c[7:0]};
		foreach (m[i])
			byte_queue.push_back(m[i]);
	endtask

	// Raw prelude with arbitrary lengths and a valid CRC, used for length faults.
	task automatic queue_prelude(input logic [31:0] tl, input logic [31:0] hl);
		logic [7:0] m[$];
		logic [31:0] c;
		m = {tl[31:24], tl[23:16], tl[15:8], tl[7:0], hl[31:24], hl[23:16], hl[15:8], hl[7:0]};
		c = crc_of(m);
		m = {m, c[31:24], c[23:16], c[15:8], c[7:0]};
		foreach (m[i])
			byte_queue.push_back(m[i]);
	endtask

	// One header: name, type, value.
	task automatic add_header(ref logic [7:0] h[$], input logic [7:0] name[$],
			input logic [7:0] val[$]);
		logic [15:0] vl;
		vl = val.size();
		h.push_back(name.size());
		h = {h, name};
		h.push_back($urandom_range(0, 255));
		h.push_back(vl[15:8]);
		h.push_back(vl[7:0]);
		h = {h, val};
	endtask

	function automatic logic [7:0] exc_text_byte(input int i);
		return exc_char(i[3:0]);
	endfunction

	// Random header block: plain values, "exception", near misses, and now and
	// then a block cut short inside a header.
	task automatic random_headers(ref logic [7:0] h[$]);
		logic [7:0] name[$];
		logic [7:0] val[$];
		int n;
		int k;
		n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			name = {};
			val = {};
			k = $urandom_range(0, 4);
			for (int j = 0; j < k; j++)
				name.push_back($urandom_range(0, 255));
			k = $urandom_range(0, 3);
			if (k == 0) begin
				for (int j = 0; j < 9; j++)
					val.push_back(exc_text_byte(j));
			end else if (k == 1) begin
				for (int j = 0; j < 9; j++)
					val.push_back(exc_text_byte(j));
				val[$urandom_range(0, 8)] ^= 8'h01 << $urandom_range(0, 7);
			end else begin
				k = $urandom_range(0, 10);
				for (int j = 0; j < k; j++)
					val.push_back($urandom_range(0, 255));
			end
			add_header(h, name, val);
		end
		if (h.size() != 0 && $urandom_range(0, 5) == 0)
			h = h[0:$urandom_range(0, h.size() - 1)];
	endtask

	// Waits until every result has arrived, then lets the pipeline settle.
	task automatic drain();
		while (byte_queue.size() != 0 || result_queue.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [23:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		max_len = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [7:0] h[$];
		logic [7:0] p[$];
		logic [7:0] nm[$];
		logic [7:0] ex[$];
		int sent;
		int k;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'd0;
		m_axis_tready = 1'b1;
		cfg_valid = 1'b0;
		cfg_data = 24'd0;
		error_count = 0;
		send_idle_ok = 0;
		recv_idle_ok = 0;
		in_taken = 0;
		max_len = 24'hFFFFFF;
		clear_parse();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: a minimal message, an exception header, every fault.
		h = {};
		p = {};
		queue_message(h, p, 0, 0);
		nm = {8'h41};
		ex = {};
		for (int j = 0; j < 9; j++)
			ex.push_back(exc_text_byte(j));
		add_header(h, nm, ex);
		p = {8'h00, 8'hFF, 8'h5A};
		queue_message(h, p, 0, 0);
		queue_message(h, p, 0, 1);
		queue_message(h, p, 1, 0);
		queue_prelude(32'd15, 32'd0);           // total below the minimum
		queue_prelude(32'd20, 32'd5);           // header longer than allowed
		queue_prelude(32'hFF000010, 32'd0);     // total does not fit in 24 bits
		queue_prelude(32'd16, 32'hFFFFFFFF);    // header length overflow
		h = {8'h00, 8'h07, 8'h00};              // header cut short inside the value length
		p = {8'h80};
		queue_message(h, p, 0, 0);
		drain();

		// Smallest allowed limit, then random streams at several limits.
		write_max_len(24'd16);
		h = {};
		p = {};
		queue_message(h, p, 0, 0);
		p = {8'h01};
		queue_message(h, p, 0, 0);
		drain();
		send_idle_ok = 1;
		recv_idle_ok = 1;
		sent = 0;
		for (int phase_no = 0; phase_no < 4; phase_no++) begin
			case (phase_no)
				0: write_max_len(24'd40);
				1: write_max_len($urandom_range(16, 80));
				2: write_max_len(24'hFFFFFF);
				default: write_max_len(24'd64);
			endcase
			while (sent < 350 * (phase_no + 1)) begin
				k = $urandom_range(0, 19);
				h = {};
				p = {};
				if (k < 15) begin
					random_headers(h);
					for (int j = $urandom_range(0, 20); j > 0; j--)
						p.push_back($urandom_range(0, 255));
					queue_message(h, p, k == 13, k == 14);
					sent += 16 + h.size() + p.size();
				end else if (k < 18) begin
					queue_prelude($urandom(), $urandom_range(0, 3) ? $urandom_range(0, 40)
						: $urandom());
					sent += 12;
				end else begin
					// Noise bytes; the parse resynchronizes on each bad prelude.
					for (int j = 0; j < 12; j++)
						byte_queue.push_back($urandom_range(0, 255));
					sent += 12;
				end
			end
			drain();
		end

		send_idle_ok = 0;
		recv_idle_ok = 0;
		drain();
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/esd_pkg.sv
rtl/esd_parser.sv
rtl/esd_queue.sv
rtl/event_stream_deframer_crc32_top.sv
rtl/esd_checker.sv
test/tb_event_stream_deframer_crc32_top.sv
